/* hw/rtl/scwc_pkg.sv */
package scwc_pkg;

	// default sizes, handed to the top level parameters
	localparam int unsigned DEF_MAX_IMAGE_DIM  = 64;
	localparam int unsigned DEF_MAX_FILTER_DIM = 8;

	// fixed field widths
	localparam int unsigned DATA_W     = 16;
	localparam int unsigned PROD_W     = 2 * DATA_W;
	localparam int unsigned SUM_W      = 40;
	localparam int unsigned POS_W      = 6;
	localparam int unsigned REQ_W      = 2;
	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 7;
	localparam int unsigned IMG_REG_W  = 7;
	localparam int unsigned FLT_REG_W  = 4;

	// register values after reset
	localparam logic [IMG_REG_W-1:0] RST_IMG_DIM    = 7'd64;
	localparam logic [FLT_REG_W-1:0] RST_FLT_DIM    = 4'd3;
	localparam logic [FLT_REG_W-1:0] RST_STRIDE     = 4'd1;

	// request kinds
	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD_FLT = 2'd0,
		REQ_LOAD_IMG = 2'd1,
		REQ_COMPUTE  = 2'd2
	} req_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMG_H    = 3'd0,
		CFG_IMG_W    = 3'd1,
		CFG_FLT_H    = 3'd2,
		CFG_FLT_W    = 3'd3,
		CFG_STRIDE_R = 3'd4,
		CFG_STRIDE_C = 3'd5
	} cfg_idx_t;

	// raw configuration registers
	typedef struct packed {
		logic [IMG_REG_W-1:0] img_h;
		logic [IMG_REG_W-1:0] img_w;
		logic [FLT_REG_W-1:0] flt_h;
		logic [FLT_REG_W-1:0] flt_w;
		logic [FLT_REG_W-1:0] stride_r;
		logic [FLT_REG_W-1:0] stride_c;
	} cfg_regs_t;

	// microprogram addresses
	typedef enum logic [2:0] {
		UPC_IDLE     = 3'd0,
		UPC_CALC     = 3'd1,
		UPC_CHECK    = 3'd2,
		UPC_MAC      = 3'd3,
		UPC_DRAIN_A  = 3'd4,
		UPC_DRAIN_B  = 3'd5,
		UPC_EMIT_OK  = 3'd6,
		UPC_EMIT_ERR = 3'd7
	} upc_t;

	// jump conditions
	typedef enum logic [2:0] {
		COND_ALWAYS   = 3'd0,
		COND_START    = 3'd1,
		COND_WIN_ERR  = 3'd2,
		COND_LAST_TAP = 3'd3,
		COND_OUT_FREE = 3'd4
	} cond_t;

	// one control word
	typedef struct packed {
		logic  in_rdy;
		logic  calc;
		logic  init;
		logic  issue;
		logic  emit_ok;
		logic  emit_err;
		cond_t cond;
		upc_t  next_t;
		upc_t  next_f;
	} uword_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic start;
		logic win_err;
		logic last_tap;
		logic out_free;
	} dp_status_t;

	// control store
	function automatic uword_t ucode_rom(input upc_t a);
		uword_t w;
		w = '0;
		unique case (a)
			UPC_IDLE: begin
				w.in_rdy = 1'b1;
				w.cond   = COND_START;
				w.next_t = UPC_CALC;
				w.next_f = UPC_IDLE;
			end
			UPC_CALC: begin
				w.calc   = 1'b1;
				w.cond   = COND_ALWAYS;
				w.next_t = UPC_CHECK;
				w.next_f = UPC_CHECK;
			end
			UPC_CHECK: begin
				w.init   = 1'b1;
				w.cond   = COND_WIN_ERR;
				w.next_t = UPC_EMIT_ERR;
				w.next_f = UPC_MAC;
			end
			UPC_MAC: begin
				w.issue  = 1'b1;
				w.cond   = COND_LAST_TAP;
				w.next_t = UPC_DRAIN_A;
				w.next_f = UPC_MAC;
			end
			UPC_DRAIN_A: begin
				w.cond   = COND_ALWAYS;
				w.next_t = UPC_DRAIN_B;
				w.next_f = UPC_DRAIN_B;
			end
			UPC_DRAIN_B: begin
				w.cond   = COND_ALWAYS;
				w.next_t = UPC_EMIT_OK;
				w.next_f = UPC_EMIT_OK;
			end
			UPC_EMIT_OK: begin
				w.emit_ok = 1'b1;
				w.cond    = COND_OUT_FREE;
				w.next_t  = UPC_IDLE;
				w.next_f  = UPC_EMIT_OK;
			end
			UPC_EMIT_ERR: begin
				w.emit_err = 1'b1;
				w.cond     = COND_OUT_FREE;
				w.next_t   = UPC_IDLE;
				w.next_f   = UPC_EMIT_ERR;
			end
		endcase
		return w;
	endfunction

	// zero counts as one, values above the limit count as the limit
	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		int unsigned r;
		r = v;
		if (v < 1) begin
			r = 1;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/scwc_useq.sv */
module scwc_useq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scwc_pkg::dp_status_t st,
	output scwc_pkg::uword_t     ctl
);
	import scwc_pkg::*;

	upc_t upc_q;
	logic take;

	// fetch the control word for the current step
	assign ctl = ucode_rom(upc_q);

	// jump condition select
	always_comb begin
		unique case (ctl.cond)
			COND_ALWAYS:   take = 1'b1;
			COND_START:    take = st.start;
			COND_WIN_ERR:  take = st.win_err;
			COND_LAST_TAP: take = st.last_tap;
			COND_OUT_FREE: take = st.out_free;
			default:       take = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
		end else begin
			upc_q <= take ? ctl.next_t : ctl.next_f;
		end
	end

endmodule

/* hw/rtl/scwc_datapath.sv */
module scwc_datapath #(
	parameter int unsigned MAX_IMAGE_DIM  = scwc_pkg::DEF_MAX_IMAGE_DIM,
	parameter int unsigned MAX_FILTER_DIM = scwc_pkg::DEF_MAX_FILTER_DIM
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  scwc_pkg::cfg_regs_t             cfg,
	input  scwc_pkg::uword_t                ctl,
	output scwc_pkg::dp_status_t            st,
	input  logic                            in_valid,
	input  logic [scwc_pkg::REQ_W-1:0]      in_req,
	input  logic [scwc_pkg::POS_W-1:0]      in_row,
	input  logic [scwc_pkg::POS_W-1:0]      in_col,
	input  logic [scwc_pkg::DATA_W-1:0]     in_value,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [scwc_pkg::SUM_W-1:0]      out_sum,
	output logic                            out_status
);
	import scwc_pkg::*;

	localparam int unsigned IDIM_W    = $clog2(MAX_IMAGE_DIM + 1);
	localparam int unsigned FDIM_W    = $clog2(MAX_FILTER_DIM + 1);
	localparam int unsigned FIDX_W    = (MAX_FILTER_DIM > 1) ? $clog2(MAX_FILTER_DIM) : 1;
	localparam int unsigned IMG_DEPTH = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
	localparam int unsigned FLT_DEPTH = MAX_FILTER_DIM * MAX_FILTER_DIM;
	localparam int unsigned IADDR_W   = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam int unsigned FADDR_W   = (FLT_DEPTH > 1) ? $clog2(FLT_DEPTH) : 1;
	localparam int unsigned ORG_W     = POS_W + FDIM_W;
	localparam int unsigned CMP_W     = ((ORG_W > IDIM_W) ? ORG_W : IDIM_W) + 1;

	logic [IDIM_W-1:0]  ih, iw;
	logic [FDIM_W-1:0]  fh, fw, sr, sc;
	logic               in_acc, img_we, flt_we;
	logic [IADDR_W-1:0] img_waddr, img_addr;
	logic [FADDR_W-1:0] flt_waddr, flt_addr;
	logic [POS_W-1:0]   row_q, col_q;
	logic [ORG_W-1:0]   r0_q, c0_q;
	logic [FIDX_W-1:0]  fi_q, fj_q;
	logic [IADDR_W-1:0] img_row_q;
	logic [FADDR_W-1:0] flt_row_q;
	logic               fi_end, fj_end, out_free, emit;
	logic [DATA_W-1:0]  img_mem [IMG_DEPTH];
	logic [DATA_W-1:0]  flt_mem [FLT_DEPTH];
	logic signed [DATA_W-1:0] img_rd_s1, flt_rd_s1;
	logic               rd_v_s1, prod_v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic [SUM_W-1:0]   acc_q;
	logic               out_v_q, out_stat_q;
	logic [SUM_W-1:0]   out_sum_q;

	// register values clamped into their ranges
	assign ih = IDIM_W'(clamp_dim(32'(cfg.img_h), MAX_IMAGE_DIM));
	assign iw = IDIM_W'(clamp_dim(32'(cfg.img_w), MAX_IMAGE_DIM));
	assign fh = FDIM_W'(clamp_dim(32'(cfg.flt_h), MAX_FILTER_DIM));
	assign fw = FDIM_W'(clamp_dim(32'(cfg.flt_w), MAX_FILTER_DIM));
	assign sr = FDIM_W'(clamp_dim(32'(cfg.stride_r), MAX_FILTER_DIM));
	assign sc = FDIM_W'(clamp_dim(32'(cfg.stride_c), MAX_FILTER_DIM));

	// input decode, out-of-range loads are dropped
	assign in_acc    = in_valid && ctl.in_rdy;
	assign flt_we    = in_acc && (in_req == REQ_LOAD_FLT) &&
	                   (32'(in_row) < MAX_FILTER_DIM) && (32'(in_col) < MAX_FILTER_DIM);
	assign img_we    = in_acc && (in_req == REQ_LOAD_IMG) &&
	                   (32'(in_row) < MAX_IMAGE_DIM) && (32'(in_col) < MAX_IMAGE_DIM);
	assign flt_waddr = FADDR_W'(32'(in_row) * MAX_FILTER_DIM + 32'(in_col));
	assign img_waddr = IADDR_W'(32'(in_row) * MAX_IMAGE_DIM + 32'(in_col));

	// tap addresses from the window walk
	assign img_addr = img_row_q + IADDR_W'(c0_q) + IADDR_W'(fj_q);
	assign flt_addr = flt_row_q + FADDR_W'(fj_q);
	assign fj_end   = (FDIM_W'(fj_q) + FDIM_W'(1)) == fw;
	assign fi_end   = (FDIM_W'(fi_q) + FDIM_W'(1)) == fh;

	// flags for the sequencer
	assign st.start    = in_acc && (in_req == REQ_COMPUTE);
	assign st.win_err  = ((CMP_W'(r0_q) + CMP_W'(fh)) > CMP_W'(ih)) ||
	                     ((CMP_W'(c0_q) + CMP_W'(fw)) > CMP_W'(iw));
	assign st.last_tap = fi_end && fj_end;
	assign st.out_free = out_free;

	// query position and window origin
	always_ff @(posedge clk) begin
		if (st.start) begin
			row_q <= in_row;
			col_q <= in_col;
		end
		if (ctl.calc) begin
			r0_q <= ORG_W'(row_q) * ORG_W'(sr);
			c0_q <= ORG_W'(col_q) * ORG_W'(sc);
		end
	end

	// window walk counters
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			fi_q      <= '0;
			fj_q      <= '0;
			img_row_q <= IADDR_W'(32'(r0_q) * MAX_IMAGE_DIM);
			flt_row_q <= '0;
		end else if (ctl.issue) begin
			if (fj_end) begin
				fj_q      <= '0;
				fi_q      <= fi_q + FIDX_W'(1);
				img_row_q <= img_row_q + IADDR_W'(MAX_IMAGE_DIM);
				flt_row_q <= flt_row_q + FADDR_W'(MAX_FILTER_DIM);
			end else begin
				fj_q <= fj_q + FIDX_W'(1);
			end
		end
	end

	// image store, one write and one registered read
	always_ff @(posedge clk) begin
		if (img_we) begin
			img_mem[img_waddr] <= in_value;
		end
		img_rd_s1 <= img_mem[img_addr];
	end

	// filter store, one write and one registered read
	always_ff @(posedge clk) begin
		if (flt_we) begin
			flt_mem[flt_waddr] <= in_value;
		end
		flt_rd_s1 <= flt_mem[flt_addr];
	end

	// multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= img_rd_s1 * flt_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1   <= 1'b0;
			prod_v_s2 <= 1'b0;
		end else begin
			rd_v_s1   <= ctl.issue;
			prod_v_s2 <= rd_v_s1;
		end
	end

	// accumulator, wraps modulo the sum width
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + SUM_W'(prod_s2);
		end
	end

	// result register
	assign out_free = !out_v_q || out_ready;
	assign emit     = (ctl.emit_ok || ctl.emit_err) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_sum_q  <= ctl.emit_err ? '0 : acc_q;
			out_stat_q <= ctl.emit_err;
		end
	end

	assign out_valid  = out_v_q;
	assign out_sum    = out_sum_q;
	assign out_status = out_stat_q;

endmodule

/* hw/rtl/strided_conv2d_window_core.sv */
// channel  | direction | signals                                   | item
// s        | in        | s_tvalid s_tready s_tdata s_tuser         | load or query
// m        | out       | m_tvalid m_tready m_tdata m_tuser         | window sum and status
// cfg      | in        | cfg_valid cfg_ready cfg_index cfg_data    | register write
//
// a load is accepted in the idle step; a query steps through the accept step, setup,
// the filter_height * filter_width taps of the single shared multiply-accumulate that
// reads one image and one filter tap per cycle, the read/multiply drain and the handoff.
// a query whose window leaves the image skips the walk and the drain.
// reset clears control, config and the result valid flag; stores hold no reset value.
// a finished result waits in the output register while the next item is taken in;
// a query whose result register is still full waits at its last step.
module strided_conv2d_window_core #(
	parameter int unsigned MAX_IMAGE_DIM  = scwc_pkg::DEF_MAX_IMAGE_DIM,
	parameter int unsigned MAX_FILTER_DIM = scwc_pkg::DEF_MAX_FILTER_DIM
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [scwc_pkg::IN_DATA_W-1:0]      s_tdata,  // row, col, value, zero pad
	input  logic [scwc_pkg::REQ_W-1:0]          s_tuser,  // req_type
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [scwc_pkg::SUM_W-1:0]          m_tdata,  // sum
	output logic [0:0]                          m_tuser,  // status
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [scwc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scwc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import scwc_pkg::*;

	cfg_regs_t  cfg_q;
	uword_t     ctl;
	dp_status_t st;
	logic       out_status;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.img_h    <= RST_IMG_DIM;
			cfg_q.img_w    <= RST_IMG_DIM;
			cfg_q.flt_h    <= RST_FLT_DIM;
			cfg_q.flt_w    <= RST_FLT_DIM;
			cfg_q.stride_r <= RST_STRIDE;
			cfg_q.stride_c <= RST_STRIDE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IMG_H:    cfg_q.img_h    <= cfg_data[IMG_REG_W-1:0];
				CFG_IMG_W:    cfg_q.img_w    <= cfg_data[IMG_REG_W-1:0];
				CFG_FLT_H:    cfg_q.flt_h    <= cfg_data[FLT_REG_W-1:0];
				CFG_FLT_W:    cfg_q.flt_w    <= cfg_data[FLT_REG_W-1:0];
				CFG_STRIDE_R: cfg_q.stride_r <= cfg_data[FLT_REG_W-1:0];
				CFG_STRIDE_C: cfg_q.stride_c <= cfg_data[FLT_REG_W-1:0];
				default:      ;
			endcase
		end
	end

	// microprogram sequencer
	scwc_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctl    (ctl)
	);

	// stores, multiply-accumulate and result register
	scwc_datapath #(
		.MAX_IMAGE_DIM  (MAX_IMAGE_DIM),
		.MAX_FILTER_DIM (MAX_FILTER_DIM)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.ctl        (ctl),
		.st         (st),
		.in_valid   (s_tvalid),
		.in_req     (s_tuser),
		.in_row     (s_tdata[POS_W-1:0]),
		.in_col     (s_tdata[2*POS_W-1:POS_W]),
		.in_value   (s_tdata[2*POS_W+DATA_W-1:2*POS_W]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_sum    (m_tdata),
		.out_status (out_status)
	);

	assign s_tready = ctl.in_rdy;
	assign m_tuser  = out_status;

endmodule

/* hw/rtl/scwc_checker.sv */
module scwc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [scwc_pkg::REQ_W-1:0]          s_tuser,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [scwc_pkg::SUM_W-1:0]          m_tdata,
	input logic [0:0]                          m_tuser
);
	import scwc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an out-of-window result carries a zero sum
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("error result with nonzero sum");

	// a query keeps the input closed through its setup steps
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == REQ_COMPUTE) |=> !s_tready ##1 !s_tready)
		else $error("input reopened during query setup");

	// no result once reset has been seen by a clock edge
	a_rst_quiet: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid in reset");

endmodule

bind strided_conv2d_window_core scwc_checker u_scwc_checker (.*);
